// ----- hw/rtl/jsid_pkg.sv -----
// Shared widths and key strings for the sync-id extractor.
package jsid_pkg;

  localparam int unsigned TextW     = 8;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned VerKeyLen = 9;
  localparam int unsigned IdKeyLen  = 20;
  localparam int unsigned VerProgW  = 4;
  localparam int unsigned IdProgW   = 5;
  localparam int unsigned DigitCntW = 6;

  localparam logic [TextW-1:0] ChQuote = 8'h22;
  localparam logic [TextW-1:0] ChColon = 8'h3a;
  localparam logic [TextW-1:0] ChOne   = 8'h31;

  localparam logic [TextW-1:0] VerKey [VerKeyLen] = '{
    8'h22, "v", "e", "r", "s", "i", "o", "n", 8'h22
  };

  localparam logic [TextW-1:0] IdKey [IdKeyLen] = '{
    8'h22, "k", "o", "r", "e", "a", "d", "e", "r", "P",
    "a", "r", "t", "i", "a", "l", "M", "d", "5", 8'h22
  };

  // Matcher phases, one-hot.
  typedef enum logic [5:0] {
    PhKey   = 6'b000001,
    PhColon = 6'b000010,
    PhValue = 6'b000100,
    PhBody  = 6'b001000,
    PhOk    = 6'b010000,
    PhFail  = 6'b100000
  } phase_e;

endpackage

// ----- hw/rtl/jsid_in_if.sv -----
// Byte stream channel into the sync-id extractor.
interface jsid_in_if;
  logic                          valid;
  logic                          ready;
  logic [jsid_pkg::TextW-1:0]    text_byte;
  logic                          is_final;

  modport source (output valid, output text_byte, output is_final, input ready);
  modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

// ----- hw/rtl/jsid_out_if.sv -----
// Result channel out of the sync-id extractor.
interface jsid_out_if;
  logic                          valid;
  logic                          ready;
  logic                          id_found;
  logic [jsid_pkg::HalfW-1:0]    id_half;
  logic                          half_last;

  modport source (output valid, output id_found, output id_half, output half_last,
                  input ready);
  modport sink   (input valid, input id_found, input id_half, input half_last,
                  output ready);
endinterface

// ----- hw/rtl/json_sync_id_extractor_unit.sv -----
// Top level: streaming extractor of the version check and the 32-digit sync id.
// The final byte's two result transfers are registered into the result queue and offered after any older results.
// Throughput: one byte per cycle; each document yields two result transfers.
// Input stalls only while the two-document result queue is full.
// Reset (rst_ni low, asynchronous) clears matchers, digit count and result queue.
module json_sync_id_extractor_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsid_in_if.sink       in_i,
  jsid_out_if.source    out_o
);

  localparam logic [jsid_pkg::DigitCntW-1:0] DigitsDone = 6'd32;

  // ---------------------------------------------------------------------------
  // Matcher state
  // ---------------------------------------------------------------------------
  logic [jsid_pkg::VerProgW-1:0]  ver_prog_q, ver_prog_d;
  jsid_pkg::phase_e               ver_phase_q, ver_phase_d;
  logic [jsid_pkg::IdProgW-1:0]   id_prog_q, id_prog_d;
  jsid_pkg::phase_e               id_phase_q, id_phase_d;
  logic [jsid_pkg::DigitCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic [jsid_pkg::HalfW-1:0]     nib0_q, nib0_d;
  logic [jsid_pkg::HalfW-1:0]     nib1_q, nib1_d;

  // ---------------------------------------------------------------------------
  // Result queue: two documents, each drained as two transfers
  // ---------------------------------------------------------------------------
  logic                       slot_found_q [2];
  logic [jsid_pkg::HalfW-1:0] slot_h0_q    [2];
  logic [jsid_pkg::HalfW-1:0] slot_h1_q    [2];
  logic                       wr_ptr_q, rd_ptr_q, half_sel_q;
  logic [1:0]                 cnt_q, cnt_d;

  logic                       in_xfer, out_xfer, push, pop;
  logic [jsid_pkg::TextW-1:0] c;
  logic                       is_space, is_digit, is_lhex, hex_ok;
  logic [3:0]                 hex_val;

  // Key matcher next-progress logic
  logic [jsid_pkg::VerProgW-1:0] ver_p, ver_p_nx;
  logic                          ver_hit;
  logic [jsid_pkg::IdProgW-1:0]  id_p, id_p_nx;
  logic                          id_hit;

  logic ver_ok, found;

  assign c = in_i.text_byte;

  assign in_i.ready = (cnt_q != 2'd2);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_xfer    = out_o.valid & out_o.ready;
  assign push        = in_xfer & in_i.is_final;
  assign pop         = out_xfer & half_sel_q;

  // Character classes
  assign is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_lhex  = (c >= 8'h61) && (c <= 8'h66);
  assign hex_ok   = is_digit | is_lhex;
  assign hex_val  = is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);

  // Version key: a mismatch restarts at one if the byte is a quote, else at zero.
  always_comb begin
    ver_p    = (ver_prog_q >= jsid_pkg::VerProgW'(jsid_pkg::VerKeyLen)) ? '0 : ver_prog_q;
    ver_p_nx = (c == jsid_pkg::VerKey[ver_p]) ? 4'(ver_p + 4'd1)
             : ((c == jsid_pkg::ChQuote) ? 4'd1 : 4'd0);
    ver_hit  = (ver_p_nx == jsid_pkg::VerProgW'(jsid_pkg::VerKeyLen));
  end

  always_comb begin
    id_p    = (id_prog_q >= jsid_pkg::IdProgW'(jsid_pkg::IdKeyLen)) ? '0 : id_prog_q;
    id_p_nx = (c == jsid_pkg::IdKey[id_p]) ? 5'(id_p + 5'd1)
            : ((c == jsid_pkg::ChQuote) ? 5'd1 : 5'd0);
    id_hit  = (id_p_nx == jsid_pkg::IdProgW'(jsid_pkg::IdKeyLen));
  end

  // Version checker: key, colon, '1', then anything but a digit.
  always_comb begin
    ver_prog_d  = ver_prog_q;
    ver_phase_d = ver_phase_q;
    unique case (ver_phase_q)
      jsid_pkg::PhKey: begin
        ver_prog_d = ver_hit ? '0 : ver_p_nx;
        if (ver_hit) ver_phase_d = jsid_pkg::PhColon;
      end
      jsid_pkg::PhColon: begin
        if (!is_space) ver_phase_d = (c == jsid_pkg::ChColon) ? jsid_pkg::PhValue
                                                              : jsid_pkg::PhFail;
      end
      jsid_pkg::PhValue: begin
        if (!is_space) ver_phase_d = (c == jsid_pkg::ChOne) ? jsid_pkg::PhBody
                                                            : jsid_pkg::PhFail;
      end
      jsid_pkg::PhBody: begin
        ver_phase_d = is_digit ? jsid_pkg::PhFail : jsid_pkg::PhOk;
      end
      jsid_pkg::PhOk: begin
        ver_phase_d = jsid_pkg::PhOk;
      end
      default: begin
        ver_phase_d = jsid_pkg::PhFail;
      end
    endcase
  end

  // Id checker: key, colon, quote, 32 lower-case hex digits, quote.
  always_comb begin
    id_prog_d  = id_prog_q;
    id_phase_d = id_phase_q;
    dig_cnt_d  = dig_cnt_q;
    nib0_d     = nib0_q;
    nib1_d     = nib1_q;
    unique case (id_phase_q)
      jsid_pkg::PhKey: begin
        id_prog_d = id_hit ? '0 : id_p_nx;
        if (id_hit) id_phase_d = jsid_pkg::PhColon;
      end
      jsid_pkg::PhColon: begin
        if (!is_space) id_phase_d = (c == jsid_pkg::ChColon) ? jsid_pkg::PhValue
                                                             : jsid_pkg::PhFail;
      end
      jsid_pkg::PhValue: begin
        if (!is_space) id_phase_d = (c == jsid_pkg::ChQuote) ? jsid_pkg::PhBody
                                                             : jsid_pkg::PhFail;
      end
      jsid_pkg::PhBody: begin
        if (dig_cnt_q >= DigitsDone) begin
          id_phase_d = (c == jsid_pkg::ChQuote) ? jsid_pkg::PhOk : jsid_pkg::PhFail;
        end else if (!hex_ok) begin
          id_phase_d = jsid_pkg::PhFail;
        end else begin
          // Digits 0-15 fill the first half, 16-31 the second.
          if (dig_cnt_q[4]) nib1_d = {nib1_q[jsid_pkg::HalfW-5:0], hex_val};
          else              nib0_d = {nib0_q[jsid_pkg::HalfW-5:0], hex_val};
          dig_cnt_d = 6'(dig_cnt_q + 6'd1);
        end
      end
      jsid_pkg::PhOk: begin
        id_phase_d = jsid_pkg::PhOk;
      end
      default: begin
        id_phase_d = jsid_pkg::PhFail;
      end
    endcase
  end

  // A '1' as the very last byte still counts as a good version.
  assign ver_ok = (ver_phase_d == jsid_pkg::PhBody) || (ver_phase_d == jsid_pkg::PhOk);
  assign found  = ver_ok && (id_phase_d == jsid_pkg::PhOk);

  // Advance matchers on each byte transfer; return to reset after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_prog_q  <= '0;
      ver_phase_q <= jsid_pkg::PhKey;
      id_prog_q   <= '0;
      id_phase_q  <= jsid_pkg::PhKey;
      dig_cnt_q   <= '0;
      nib0_q      <= '0;
      nib1_q      <= '0;
    end else if (in_xfer) begin
      if (in_i.is_final) begin
        ver_prog_q  <= '0;
        ver_phase_q <= jsid_pkg::PhKey;
        id_prog_q   <= '0;
        id_phase_q  <= jsid_pkg::PhKey;
        dig_cnt_q   <= '0;
        nib0_q      <= '0;
        nib1_q      <= '0;
      end else begin
        ver_prog_q  <= ver_prog_d;
        ver_phase_q <= ver_phase_d;
        id_prog_q   <= id_prog_d;
        id_phase_q  <= id_phase_d;
        dig_cnt_q   <= dig_cnt_d;
        nib0_q      <= nib0_d;
        nib1_q      <= nib1_d;
      end
    end
  end

  // Result queue payload: drop the halves to zero when the id is not found.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_found_q[wr_ptr_q] <= found;
      slot_h0_q[wr_ptr_q]    <= found ? nib0_d : '0;
      slot_h1_q[wr_ptr_q]    <= found ? nib1_d : '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop)      cnt_d = 2'(cnt_q + 2'd1);
    else if (pop && !push) cnt_d = 2'(cnt_q - 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      half_sel_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push)     wr_ptr_q   <= ~wr_ptr_q;
      if (pop)      rd_ptr_q   <= ~rd_ptr_q;
      if (out_xfer) half_sel_q <= ~half_sel_q;
    end
  end

  assign out_o.id_found  = slot_found_q[rd_ptr_q];
  assign out_o.id_half   = half_sel_q ? slot_h1_q[rd_ptr_q] : slot_h0_q[rd_ptr_q];
  assign out_o.half_last = half_sel_q;

endmodule

// ----- tb/sv/jsid_sync_id_checker.sv -----
// Checker for the sync-id extractor: predicts each document's two results and compares them.
module jsid_sync_id_checker
  import jsid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  jsid_in_if          in_mon_i,
  jsid_out_if         out_mon_i,
  output int unsigned err_cnt_o,
  output int unsigned open_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TextW-1:0] ChSpace = 8'h20;
  localparam logic [TextW-1:0] ChTab   = 8'h09;
  localparam logic [TextW-1:0] ChCr    = 8'h0d;
  localparam logic [TextW-1:0] ChLf    = 8'h0a;
  localparam logic [TextW-1:0] ChZero  = 8'h30;
  localparam logic [TextW-1:0] ChNine  = 8'h39;
  localparam logic [TextW-1:0] ChLowA  = 8'h61;
  localparam logic [TextW-1:0] ChLowF  = 8'h66;
  localparam int unsigned      IdDigits = 32;

  typedef struct packed {
    logic             found;
    logic [HalfW-1:0] half;
    logic             last;
  } id_half_t;

  id_half_t               pending_halves[$];
  logic [VerProgW-1:0]    ver_prog;
  phase_e                 ver_ph;
  logic [IdProgW-1:0]     id_prog;
  phase_e                 id_ph;
  logic [DigitCntW-1:0]   digit_cnt;
  logic [HalfW-1:0]       id_acc [2];
  int unsigned            errs;

  function automatic logic is_ws(logic [TextW-1:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  // Key progress after one byte; a mismatch restarts at 1 on a quote, else at 0.
  function automatic int next_prog(logic use_ver, int prog, logic [TextW-1:0] c);
    int               klen;
    int               p;
    logic [TextW-1:0] want;
    klen = use_ver ? VerKeyLen : IdKeyLen;
    p = (prog >= klen) ? 0 : prog;
    if (use_ver) want = VerKey[VerProgW'(p)];
    else want = IdKey[IdProgW'(p)];
    if (c == want) p++;
    else p = (c == ChQuote) ? 1 : 0;
    return p;
  endfunction

  // Bit 4 flags a valid lower-case hex digit.
  function automatic logic [4:0] hex_nibble(logic [TextW-1:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b1, c[3:0]};
    if (c >= ChLowA && c <= ChLowF) return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'b0;
  endfunction

  function automatic void clear_doc();
    ver_prog  = '0;
    ver_ph    = PhKey;
    id_prog   = '0;
    id_ph     = PhKey;
    digit_cnt = '0;
    id_acc[0] = '0;
    id_acc[1] = '0;
  endfunction

  // Advance both matchers by one byte; on the final byte queue the two halves.
  function automatic void scan_byte(logic [TextW-1:0] c, logic fin);
    int         p;
    logic [4:0] hv;
    logic       found;
    id_half_t   rec;
    case (ver_ph)
      PhKey: begin
        p = next_prog(1'b1, int'(ver_prog), c);
        if (p == VerKeyLen) begin
          ver_prog = '0;
          ver_ph   = PhColon;
        end else begin
          ver_prog = VerProgW'(p);
        end
      end
      PhColon: if (!is_ws(c)) ver_ph = (c == ChColon) ? PhValue : PhFail;
      PhValue: if (!is_ws(c)) ver_ph = (c == ChOne) ? PhBody : PhFail;
      PhBody:  ver_ph = (c >= ChZero && c <= ChNine) ? PhFail : PhOk;
      PhOk:    ;
      default: ver_ph = PhFail;
    endcase
    case (id_ph)
      PhKey: begin
        p = next_prog(1'b0, int'(id_prog), c);
        if (p == IdKeyLen) begin
          id_prog = '0;
          id_ph   = PhColon;
        end else begin
          id_prog = IdProgW'(p);
        end
      end
      PhColon: if (!is_ws(c)) id_ph = (c == ChColon) ? PhValue : PhFail;
      PhValue: if (!is_ws(c)) id_ph = (c == ChQuote) ? PhBody : PhFail;
      PhBody: begin
        if (digit_cnt >= IdDigits) begin
          id_ph = (c == ChQuote) ? PhOk : PhFail;
        end else begin
          hv = hex_nibble(c);
          if (!hv[4]) begin
            id_ph = PhFail;
          end else begin
            id_acc[digit_cnt[4]] = {id_acc[digit_cnt[4]][HalfW-5:0], hv[3:0]};
            digit_cnt++;
          end
        end
      end
      PhOk:    ;
      default: id_ph = PhFail;
    endcase
    if (fin) begin
      found = (ver_ph == PhBody || ver_ph == PhOk) && id_ph == PhOk;
      rec.found = found;
      rec.half  = found ? id_acc[0] : '0;
      rec.last  = 1'b0;
      pending_halves.push_back(rec);
      rec.half  = found ? id_acc[1] : '0;
      rec.last  = 1'b1;
      pending_halves.push_back(rec);
      clear_doc();
    end
  endfunction

  function automatic void check_half();
    id_half_t w;
    if (pending_halves.size() == 0) begin
      $error("result: expected none, got id_found %0b id_half %h half_last %0b",
             out_mon_i.id_found, out_mon_i.id_half, out_mon_i.half_last);
      errs++;
      return;
    end
    w = pending_halves.pop_front();
    if (out_mon_i.id_found !== w.found) begin
      $error("id_found: expected %0b, got %0b", w.found, out_mon_i.id_found);
      errs++;
    end
    if (out_mon_i.id_half !== w.half) begin
      $error("id_half: expected %h, got %h", w.half, out_mon_i.id_half);
      errs++;
    end
    if (out_mon_i.half_last !== w.last) begin
      $error("half_last: expected %0b, got %0b", w.last, out_mon_i.half_last);
      errs++;
    end
  endfunction

  // Compare first so a result can never be matched against a byte of this same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_doc();
      pending_halves.delete();
      errs = 0;
      err_cnt_o  <= 0;
      open_cnt_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) check_half();
      if (in_mon_i.valid && in_mon_i.ready) scan_byte(in_mon_i.text_byte, in_mon_i.is_final);
      err_cnt_o  <= errs;
      open_cnt_o <= pending_halves.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the sync-id extractor bench: clock, reset, byte stimulus, result sink and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jsid_pkg::*;

  localparam int unsigned ByteTarget  = 1750;
  localparam int unsigned DocTarget   = 30;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCycles = 10;

  localparam logic [TextW-1:0] WsChars [4] = '{8'h20, 8'h09, 8'h0d, 8'h0a};

  // Ways a generated document departs from a clean one.
  typedef enum int {
    FlawNone,
    FlawQuoteRestart,
    FlawWrongKey,
    FlawNoColon,
    FlawBadVersion,
    FlawLongVersion,
    FlawIdRestart,
    FlawNoOpenQuote,
    FlawUpperHex,
    FlawShortId,
    FlawLongId,
    FlawDuplicate,
    FlawTruncate
  } flaw_e;

  logic        clk_i;
  logic        rst_ni;
  bit          quiet;
  int unsigned byte_cnt;
  int unsigned doc_cnt;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned open_cnt;
  logic [TextW-1:0] doc_q[$];

  jsid_in_if  in_ch ();
  jsid_out_if out_ch ();

  json_sync_id_extractor_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  jsid_sync_id_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon_i   (in_ch),
    .out_mon_i  (out_ch),
    .err_cnt_o  (err_cnt),
    .open_cnt_o (open_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Document builders: append bytes to doc_q; the last byte carries is_final.
  // ---------------------------------------------------------------------------
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  // Mostly no whitespace, sometimes a short run of mixed blanks.
  function automatic void put_ws();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) doc_q.push_back(WsChars[2'($urandom_range(0, 3))]);
  endfunction

  function automatic void put_version(flaw_e flaw);
    case (flaw)
      FlawQuoteRestart: put_str("\"ver\"version\"");  // stray quote restarts the match
      FlawWrongKey:     put_str("\"Version\"");
      default:          put_str("\"version\"");
    endcase
    put_ws();
    doc_q.push_back((flaw == FlawNoColon) ? 8'h3d : ChColon);
    put_ws();
    doc_q.push_back((flaw == FlawBadVersion) ? 8'h32 : ChOne);
    if (flaw == FlawLongVersion) doc_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void put_id(flaw_e flaw);
    string hex_set;
    int    n;
    int    fill;
    int    bad_at;
    hex_set = "0123456789abcdef";
    if (flaw == FlawIdRestart) put_str("\"\"koreaderPartialMd5\"");
    else put_str("\"koreaderPartialMd5\"");
    put_ws();
    doc_q.push_back(ChColon);
    put_ws();
    if (flaw != FlawNoOpenQuote) doc_q.push_back(ChQuote);
    n = 32;
    if (flaw == FlawShortId) n = $urandom_range(0, 31);
    if (flaw == FlawLongId) n = $urandom_range(33, 34);
    // Occasionally fill with all zeros or all 'f' to hit the half extremes.
    fill   = $urandom_range(0, 7);
    bad_at = (flaw == FlawUpperHex) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) doc_q.push_back(8'h41 + 8'($urandom_range(0, 5)));
      else if (fill == 0) doc_q.push_back(8'h30);
      else if (fill == 1) doc_q.push_back(8'h66);
      else doc_q.push_back(hex_set[$urandom_range(0, 15)]);
    end
    doc_q.push_back(ChQuote);
  endfunction

  // A JSON-like record with both keys in random order, sometimes flawed.
  function automatic void build_record();
    flaw_e flaw;
    bit    id_first;
    int    keep;
    doc_q.delete();
    flaw = ($urandom_range(0, 2) == 0) ? flaw_e'($urandom_range(FlawQuoteRestart, FlawTruncate))
                                       : FlawNone;
    id_first = $urandom_range(0, 1);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 6)) doc_q.push_back(8'($urandom_range(0, 255)));
    doc_q.push_back(8'h7b);
    put_ws();
    if (id_first) begin
      put_id(flaw);
      put_ws();
      doc_q.push_back(8'h2c);
      put_ws();
      put_version(flaw);
    end else begin
      put_version(flaw);
      put_ws();
      doc_q.push_back(8'h2c);
      put_ws();
      put_id(flaw);
    end
    if (flaw == FlawDuplicate) begin
      // Later copies of both keys must be ignored.
      doc_q.push_back(8'h2c);
      put_id(FlawNone);
      doc_q.push_back(8'h2c);
      put_version(FlawBadVersion);
    end
    // Sometimes end right on the version digit; otherwise close the record.
    if (!(id_first && flaw != FlawDuplicate && $urandom_range(0, 2) == 0)) begin
      put_ws();
      doc_q.push_back(8'h7d);
      put_ws();
    end
    if (flaw == FlawTruncate) begin
      keep = $urandom_range(1, doc_q.size() - 1);
      while (doc_q.size() > keep) void'(doc_q.pop_back());
    end
  endfunction

  function automatic void build_noise();
    doc_q.delete();
    repeat ($urandom_range(1, 16)) doc_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: random gap before each byte, then hold until the transfer.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [TextW-1:0] b, logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.is_final  <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    byte_cnt++;
  endtask

  task automatic send_doc();
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
    doc_cnt++;
  endtask

  // Drop valid and hold the sender until every predicted half has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (open_cnt != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall before each result, none in quiet stretches.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.is_final  <= 1'b0;
    rst_ni          <= 1'b0;
    quiet    = 1'b0;
    byte_cnt = 0;
    doc_cnt  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte documents at both byte extremes.
    doc_q.delete();
    doc_q.push_back(8'hff);
    send_doc();
    doc_q.delete();
    doc_q.push_back(8'h00);
    send_doc();
    // Version key with blanks, the document ending right on the '1'; no id, so not found.
    doc_q.delete();
    put_str("\"version\" :\t\r\n1");
    send_doc();
    // Empty record.
    doc_q.delete();
    put_str("{}");
    send_doc();
    wait_drained();

    // Random part: mostly well-formed records, the rest raw noise.
    while (byte_cnt < ByteTarget || doc_cnt < DocTarget) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) build_noise();
      else build_record();
      send_doc();
      if (doc_cnt % 10 == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && open_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Abort a hung run.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
